// ===== rtl/m3inv_pkg.sv =====
package m3inv_pkg;

  localparam int NumEl   = 9;
  localparam int ElemW   = 16;
  localparam int OutW    = 32;
  localparam int ThreshW = 48;
  localparam int CofW    = 33;
  localparam int DetW    = 50;
  localparam int DivSteps = OutW;

  localparam logic [ThreshW-1:0] ThreshReset = 48'd168;

  // adj[k] = m[op0]*m[op1] - m[op2]*m[op3], k = row*3 + col
  localparam logic [0:8][0:3][3:0] CofOps = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [OutW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] SatNeg = 32'h8000_0000;

  typedef logic [NumEl-1:0][ElemW-1:0] mat_t;

  typedef struct packed {
    mat_t                        m;
    logic [NumEl-1:0][CofW-1:0]  adj;
  } cof_t;

  typedef struct packed {
    mat_t                        m;
    logic [NumEl-1:0][CofW-1:0]  adj;
    logic [DetW-1:0]             det;
  } det_t;

  typedef struct packed {
    logic [ThreshW-1:0] rem;
    logic [OutW-1:0]    rq;    // numerator low bits shift out, quotient bits shift in
    logic               ovf;
    logic               neg;
  } lane_t;

  typedef struct packed {
    lane_t [NumEl-1:0]  lane;
    logic [ThreshW-1:0] den;
    logic               sing;
    mat_t               m;
  } div_t;

endpackage

// ===== rtl/m3inv_if.sv =====
interface m3inv_mat_if;
  logic valid;
  logic ready;
  logic [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3inv_inv_if;
  logic valid;
  logic ready;
  logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic singular;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                output ready);
endinterface

interface m3inv_cfg_if;
  logic valid;
  logic ready;
  logic [47:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/m3inv_cof.sv =====
// Two stages: eighteen 16x16 products, then the nine cofactor differences.
module m3inv_cof (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3inv_pkg::mat_t   in_m,
  output logic              out_valid,
  input  logic              out_ready,
  output m3inv_pkg::cof_t   out_d
);

  logic v1;
  logic en1, en2;
  m3inv_pkg::mat_t m1;
  logic [m3inv_pkg::NumEl-1:0][31:0] pa, pb, pa_next, pb_next;

  assign en2 = !out_valid || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    for (int k = 0; k < m3inv_pkg::NumEl; k++) begin
      pa_next[k] = 32'($signed(in_m[m3inv_pkg::CofOps[k][0]]) *
                       $signed(in_m[m3inv_pkg::CofOps[k][1]]));
      pb_next[k] = 32'($signed(in_m[m3inv_pkg::CofOps[k][2]]) *
                       $signed(in_m[m3inv_pkg::CofOps[k][3]]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
    if (en1) begin
      m1 <= in_m;
      pa <= pa_next;
      pb <= pb_next;
    end
    if (en2) begin
      out_d.m <= m1;
      for (int k = 0; k < m3inv_pkg::NumEl; k++) begin
        out_d.adj[k] <= 33'($signed(pa[k])) - 33'($signed(pb[k]));
      end
    end
  end

endmodule

// ===== rtl/m3inv_det.sv =====
// Two stages: first row times first cofactor column, then the three-term sum.
module m3inv_det (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3inv_pkg::cof_t   in_d,
  output logic              out_valid,
  input  logic              out_ready,
  output m3inv_pkg::det_t   out_d
);

  logic v1;
  logic en1, en2;
  m3inv_pkg::cof_t d1;
  logic [2:0][m3inv_pkg::DetW-1:0] p, p_next;

  assign en2 = !out_valid || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p_next[j] = 50'($signed(in_d.m[j]) * $signed(in_d.adj[3*j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
    if (en1) begin
      d1 <= in_d;
      p <= p_next;
    end
    if (en2) begin
      out_d.m <= d1.m;
      out_d.adj <= d1.adj;
      out_d.det <= p[0] + p[1] + p[2];
    end
  end

endmodule

// ===== rtl/m3inv_setup.sv =====
// Singular test and divider seeding: |adj| << 24 over |det|, the bits above
// the 32 quotient bits are checked once here for overflow.
module m3inv_setup (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [m3inv_pkg::ThreshW-1:0]       thresh,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  m3inv_pkg::det_t                     in_d,
  output logic                                out_valid,
  input  logic                                out_ready,
  output m3inv_pkg::div_t                     out_d
);

  logic en;
  logic [m3inv_pkg::DetW-1:0] magd;
  m3inv_pkg::div_t d_next;
  logic [m3inv_pkg::CofW-1:0] maga;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    magd = in_d.det[m3inv_pkg::DetW-1] ? -in_d.det : in_d.det;
    maga = '0;
    d_next.m = in_d.m;
    d_next.den = magd[m3inv_pkg::ThreshW-1:0];
    d_next.sing = (in_d.det == '0) || (magd < {2'b00, thresh});
    for (int k = 0; k < m3inv_pkg::NumEl; k++) begin
      maga = in_d.adj[k][m3inv_pkg::CofW-1] ? -in_d.adj[k] : in_d.adj[k];
      d_next.lane[k].rem = {24'd0, maga[31:8]};
      d_next.lane[k].rq = {maga[7:0], 24'd0};
      d_next.lane[k].ovf = {24'd0, maga[31:8]} >= magd[m3inv_pkg::ThreshW-1:0];
      d_next.lane[k].neg = in_d.adj[k][m3inv_pkg::CofW-1] ^ in_d.det[m3inv_pkg::DetW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) out_d <= d_next;
  end

endmodule

// ===== rtl/m3inv_div_step.sv =====
// One restoring-division bit for all nine lanes.
module m3inv_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3inv_pkg::div_t   in_d,
  output logic              out_valid,
  input  logic              out_ready,
  output m3inv_pkg::div_t   out_d
);

  logic en;
  logic [m3inv_pkg::ThreshW:0] t;
  logic ge;
  m3inv_pkg::div_t d_next;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    d_next = in_d;
    t = '0;
    ge = 1'b0;
    for (int k = 0; k < m3inv_pkg::NumEl; k++) begin
      t = {in_d.lane[k].rem, in_d.lane[k].rq[m3inv_pkg::OutW-1]};
      ge = t >= {1'b0, in_d.den};
      d_next.lane[k].rem = ge ? 48'(t - {1'b0, in_d.den}) : t[m3inv_pkg::ThreshW-1:0];
      d_next.lane[k].rq = {in_d.lane[k].rq[m3inv_pkg::OutW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) out_d <= d_next;
  end

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, fully pipelined: one matrix accepted per
// clock while the output is not stalled. Stages: cofactor products, cofactor
// differences, determinant products, determinant sum, singular test and divider
// setup, 32 restoring-division steps (one quotient bit each, nine lanes in
// parallel) and the saturating output register. Inputs are Q8.8, results Q16.16
// truncated toward zero and saturated; when |det| is below singular_threshold
// (Q24.24, reset 168) or det is zero, the input comes back as Q16.16 with
// singular set. A stall at the output holds the pipeline; empty stages keep
// filling. Write the threshold only while no transaction is in flight.
module matrix3x3_inverse (
  input  logic        clk,
  input  logic        rst,
  m3inv_cfg_if.sink   cfg,
  m3inv_mat_if.sink   mat_in,
  m3inv_inv_if.source inv_out
);

  localparam int Steps = m3inv_pkg::DivSteps;

  logic [m3inv_pkg::ThreshW-1:0] thresh;
  m3inv_pkg::mat_t in_m;

  logic cof_v, cof_rdy;
  m3inv_pkg::cof_t cof_d;
  logic det_v, det_rdy;
  m3inv_pkg::det_t det_d;

  logic div_v   [Steps+1];
  logic div_rdy [Steps+1];
  m3inv_pkg::div_t div_d [Steps+1];

  logic out_en;
  logic [m3inv_pkg::NumEl-1:0][m3inv_pkg::OutW-1:0] res, res_next;
  logic sing;
  m3inv_pkg::lane_t ln;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= m3inv_pkg::ThreshReset;
    end else if (cfg.valid) begin
      thresh <= cfg.data;
    end
  end

  assign in_m = {mat_in.a22, mat_in.a21, mat_in.a20, mat_in.a12, mat_in.a11,
                 mat_in.a10, mat_in.a02, mat_in.a01, mat_in.a00};

  m3inv_cof u_cof (
    .clk(clk), .rst(rst),
    .in_valid(mat_in.valid), .in_ready(mat_in.ready), .in_m(in_m),
    .out_valid(cof_v), .out_ready(cof_rdy), .out_d(cof_d)
  );

  m3inv_det u_det (
    .clk(clk), .rst(rst),
    .in_valid(cof_v), .in_ready(cof_rdy), .in_d(cof_d),
    .out_valid(det_v), .out_ready(det_rdy), .out_d(det_d)
  );

  m3inv_setup u_setup (
    .clk(clk), .rst(rst), .thresh(thresh),
    .in_valid(det_v), .in_ready(det_rdy), .in_d(det_d),
    .out_valid(div_v[0]), .out_ready(div_rdy[0]), .out_d(div_d[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_div
    m3inv_div_step u_step (
      .clk(clk), .rst(rst),
      .in_valid(div_v[i]), .in_ready(div_rdy[i]), .in_d(div_d[i]),
      .out_valid(div_v[i+1]), .out_ready(div_rdy[i+1]), .out_d(div_d[i+1])
    );
  end

  assign out_en = !inv_out.valid || inv_out.ready;
  assign div_rdy[Steps] = out_en;

  always_comb begin
    ln = '0;
    for (int k = 0; k < m3inv_pkg::NumEl; k++) begin
      ln = div_d[Steps].lane[k];
      if (div_d[Steps].sing) begin
        res_next[k] = {{8{div_d[Steps].m[k][15]}}, div_d[Steps].m[k], 8'd0};
      end else if (!ln.neg) begin
        res_next[k] = (ln.ovf || ln.rq[31]) ? m3inv_pkg::SatPos : ln.rq;
      end else begin
        res_next[k] = (ln.ovf || (ln.rq > m3inv_pkg::SatNeg)) ? m3inv_pkg::SatNeg : -ln.rq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_out.valid <= 1'b0;
    end else if (out_en) begin
      inv_out.valid <= div_v[Steps];
    end
    if (out_en) begin
      res <= res_next;
      sing <= div_d[Steps].sing;
    end
  end

  assign inv_out.r00 = res[0];
  assign inv_out.r01 = res[1];
  assign inv_out.r02 = res[2];
  assign inv_out.r10 = res[3];
  assign inv_out.r11 = res[4];
  assign inv_out.r12 = res[5];
  assign inv_out.r20 = res[6];
  assign inv_out.r21 = res[7];
  assign inv_out.r22 = res[8];
  assign inv_out.singular = sing;

`ifndef SYNTH
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !inv_out.valid |-> mat_in.ready)
    else $error("input stalled with empty output register");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    div_v[Steps] && !div_d[Steps].sing && !div_d[Steps].lane[0].ovf
      |-> div_d[Steps].lane[0].rem < div_d[Steps].den)
    else $error("division remainder not below divisor");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !inv_out.valid)
    else $error("result valid right after reset");
`endif

endmodule
